// File: rtl/core/h264p_pkg.sv
// Shared types and constants for the Annex B to RTP FU-A packetizer.
// No dependencies; imported by every module of the block.
package h264p_pkg;

    // configuration register indexes
    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_MTU    = 1'b1;

    // item commands
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // RTP and FU-A constants
    localparam int unsigned RTP_HEADER_BYTES = 12;
    localparam int unsigned MTU_FLOOR        = 16;
    localparam logic [7:0]  NRI_MASK         = 8'h60;
    localparam logic [7:0]  TYPE_MASK        = 8'h1f;
    localparam logic [7:0]  FU_A_TYPE        = 8'd28;
    localparam logic [4:0]  NAL_SPS          = 5'd7;
    localparam logic [4:0]  NAL_PPS          = 5'd8;
    localparam logic [11:0] MTU_RESET        = 12'd1500;

    // depth of the result queue between front and back
    localparam int unsigned Q_DEPTH = 4;

    // one payload byte with its packet flags
    typedef struct packed {
        logic [7:0]         byte_val;
        logic               pkt_first;
        logic               pkt_last;
        logic               marker;
        logic signed [31:0] ptime;
        logic               ovf;
    } t_beat;

endpackage

// File: rtl/core/h264_annexb_to_rtp_fua_packetizer.sv
// Top level: H.264 Annex B byte stream to RTP payloads (single NAL and FU-A).
// Depends on h264p_pkg, h264p_front, h264p_queue.
//
//   channel   direction  handshake               payload
//   in        sink       i_in_valid/o_in_ready   command, data_byte, end_of_unit, timestamp
//   out       source     o_out_valid/i_out_ready out_byte, packet_start/end, marker, time, overflow
//   cfg       sink       i_cfg_valid/o_cfg_ready cfg_index (0 enable, 1 mtu), cfg_data
//
// One item is accepted per cycle while input ready is high. A tick's byte is sequenced and read
// from the store into the read stage at the accepting edge, is then written into the result queue,
// and can leave from there.
// Input ready drops only when the beats in the four-entry result queue plus the read stage reach four.
// Reset is synchronous and clears all control state; the store needs no clearing.
module h264_annexb_to_rtp_fua_packetizer import h264p_pkg::*; #(
    parameter int unsigned STORE_BYTES = 2048
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_command,
    input  logic [7:0]         i_data_byte,
    input  logic               i_end_of_unit,
    input  logic signed [31:0] i_timestamp,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_out_byte,
    output logic               o_packet_start,
    output logic               o_packet_end,
    output logic               o_marker,
    output logic signed [31:0] o_packet_time,
    output logic               o_overflow,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [11:0]        i_cfg_data
);

    localparam int unsigned QW = $clog2(Q_DEPTH) + 1;

    logic          beat_valid;
    t_beat         beat;
    t_beat         q_beat;
    logic [QW-1:0] q_count;

    // reserve queue room for every beat still in the read stage
    assign o_in_ready  = ((q_count + QW'(beat_valid)) < QW'(Q_DEPTH));
    assign o_cfg_ready = 1'b1;

    h264p_front #(.STORE_BYTES(STORE_BYTES)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_acc    (i_in_valid && o_in_ready),
        .i_command     (i_command),
        .i_data_byte   (i_data_byte),
        .i_end_of_unit (i_end_of_unit),
        .i_timestamp   (i_timestamp),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_beat_valid  (beat_valid),
        .o_beat        (beat)
    );

    h264p_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (beat_valid),
        .i_beat  (beat),
        .i_pop   (i_out_ready),
        .o_valid (o_out_valid),
        .o_beat  (q_beat),
        .o_count (q_count)
    );

    assign o_out_byte     = q_beat.byte_val;
    assign o_packet_start = q_beat.pkt_first;
    assign o_packet_end   = q_beat.pkt_last;
    assign o_marker       = q_beat.marker;
    assign o_packet_time  = q_beat.ptime;
    assign o_overflow     = q_beat.ovf;

endmodule

// File: rtl/core/h264p_front.sv
// Front end: start code parser, NAL store, packet sequencer, store read stage.
// Depends on h264p_pkg. Produces one t_beat per tick that has a pending NAL.
module h264p_front import h264p_pkg::*; #(
    parameter int unsigned STORE_BYTES = 2048
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_item_acc,
    input  logic               i_command,
    input  logic [7:0]         i_data_byte,
    input  logic               i_end_of_unit,
    input  logic signed [31:0] i_timestamp,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [11:0]        i_cfg_data,
    output logic               o_beat_valid,
    output t_beat              o_beat
);

    localparam int unsigned AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int unsigned CW = $clog2(STORE_BYTES + 4);
    localparam int unsigned LW = (CW > 12) ? CW : 12;
    localparam logic [CW-1:0] STORE_C = CW'(STORE_BYTES);
    localparam logic [CW-1:0] CNT_MAX = CW'(STORE_BYTES + 3);

    localparam logic [1:0] PH_SEARCH  = 2'd0;
    localparam logic [1:0] PH_COLLECT = 2'd1;
    localparam logic [1:0] PH_DISCARD = 2'd2;

    // wrap a sum below twice the store size into the store
    function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
        logic [AW:0] t;
        t = s - (AW+1)'(STORE_BYTES);
        if (s >= (AW+1)'(STORE_BYTES)) begin
            return t[AW-1:0];
        end
        return s[AW-1:0];
    endfunction

    logic [7:0] mem [STORE_BYTES];

    logic [23:0]        r_recent, n_recent;
    logic [1:0]         r_phase, n_phase;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_coll_start, n_coll_start;
    logic [AW-1:0]      r_write_head, n_write_head;
    logic [7:0]         r_coll_hdr, n_coll_hdr;
    logic               r_unit_open, n_unit_open;
    logic signed [31:0] r_unit_time, n_unit_time;
    logic               r_ovf, n_ovf;
    logic               r_enable, n_enable;
    logic [11:0]        r_mtu, n_mtu;
    logic               r_pend_valid, n_pend_valid;
    logic [7:0]         r_hdr, n_hdr;
    logic [CW-1:0]      r_pend_len, n_pend_len;
    logic [CW-1:0]      r_remain, n_remain;
    logic [11:0]        r_chunk, n_chunk;
    logic               r_frag, n_frag;
    logic               r_first, n_first;
    logic               r_ending, n_ending;
    logic signed [31:0] r_pend_time, n_pend_time;
    logic [LW-1:0]      r_pos, n_pos;
    logic [AW-1:0]      r_ptr, n_ptr;

    logic               r_s2_valid;
    logic               r_s2_mem;
    t_beat              r_s2_beat;
    logic [7:0]         r_rdata;

    logic               acc_b, acc_t, sc, start;
    logic               fin_try, fin_last, fin_ok;
    logic [1:0]         fin_phase, phase_mid;
    logic [CW-1:0]      fin_len, count_mid, room;
    logic               wr_en, rd_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] time_cur;
    logic [11:0]        mtu_eff, limit;
    logic               emit;
    logic [CW-1:0]      pay;
    logic               last_pkt, pkt_end, mem_sel;
    logic [7:0]         lit;
    t_beat              beat_c;

    always_comb begin
        acc_b    = i_item_acc && (i_command == CMD_BYTE);
        acc_t    = i_item_acc && (i_command == CMD_TICK);
        sc       = (r_recent[15:0] == 16'h0000) && (i_data_byte == 8'h01);
        room     = r_pend_valid ? (STORE_C - r_pend_len) : STORE_C;
        time_cur = r_unit_open ? r_unit_time : i_timestamp;
        mtu_eff  = (r_mtu < 12'(MTU_FLOOR)) ? 12'(MTU_FLOOR) : r_mtu;
        limit    = mtu_eff - 12'(RTP_HEADER_BYTES);

        n_recent = r_recent;   n_phase = r_phase;     n_count = r_count;
        n_coll_start = r_coll_start;  n_write_head = r_write_head;
        n_coll_hdr = r_coll_hdr;      n_unit_open = r_unit_open;
        n_unit_time = r_unit_time;    n_ovf = r_ovf;
        n_enable = r_enable;   n_mtu = r_mtu;
        n_pend_valid = r_pend_valid;  n_hdr = r_hdr;  n_pend_len = r_pend_len;
        n_remain = r_remain;   n_chunk = r_chunk;     n_frag = r_frag;
        n_first = r_first;     n_ending = r_ending;   n_pend_time = r_pend_time;
        n_pos = r_pos;         n_ptr = r_ptr;

        start = 1'b0;  fin_try = 1'b0;  fin_last = 1'b0;  fin_len = '0;
        fin_phase = r_phase;  phase_mid = r_phase;  count_mid = r_count;
        wr_en = 1'b0;  wr_addr = wrap({1'b0, r_coll_start} + (AW+1)'(r_count));

        // apply configuration writes
        if (i_cfg_we) begin
            if (i_cfg_index == CFG_ENABLE) begin
                n_enable = i_cfg_data[0];
            end else begin
                n_mtu = i_cfg_data;
            end
        end

        // parse one stream byte
        if (acc_b) begin
            if (!r_unit_open) begin
                n_unit_time = i_timestamp;
                n_unit_open = 1'b1;
            end
            if (r_phase == PH_SEARCH) begin
                start = sc;
            end else if (sc && (r_count >= CW'(3))) begin
                fin_try = 1'b1;
                fin_len = r_count - CW'(2) - CW'(r_recent[23:16] == 8'h00);
                start   = 1'b1;
            end else begin
                if (r_phase == PH_COLLECT) begin
                    if (r_count < room) begin
                        wr_en = 1'b1;
                        if (r_count == '0) begin
                            n_coll_hdr = i_data_byte;
                        end
                    end else begin
                        phase_mid = PH_DISCARD;
                        n_ovf     = 1'b1;
                    end
                end
                if (r_count < CNT_MAX) begin
                    count_mid = r_count + CW'(1);
                end
                if (i_end_of_unit && (phase_mid != PH_SEARCH)) begin
                    fin_try   = 1'b1;
                    fin_len   = count_mid;
                    fin_last  = 1'b1;
                    fin_phase = phase_mid;
                end
            end
        end

        // decide whether the closed NAL becomes pending
        fin_ok = fin_try && (fin_phase == PH_COLLECT) && (fin_len >= CW'(2)) && r_enable
                 && (r_coll_hdr[4:0] != NAL_SPS) && (r_coll_hdr[4:0] != NAL_PPS);
        if (fin_ok) begin
            if (r_pend_valid) begin
                n_ovf = 1'b1;
            end else begin
                n_pend_valid = 1'b1;
                n_pend_len   = fin_len;
                n_ending     = fin_last;
                n_pend_time  = time_cur;
                n_hdr        = r_coll_hdr;
                n_frag       = (LW'(fin_len) > LW'(limit));
                n_chunk      = limit - 12'd2;
                n_remain     = fin_len - CW'(n_frag);
                n_first      = 1'b1;
                n_pos        = '0;
                n_ptr        = n_frag ? wrap({1'b0, r_coll_start} + (AW+1)'(1)) : r_coll_start;
                n_write_head = wrap({1'b0, r_coll_start} + (AW+1)'(fin_len));
            end
        end

        if (acc_b) begin
            if (start) begin
                n_phase      = PH_COLLECT;
                n_count      = '0;
                n_coll_start = n_write_head;
            end else begin
                n_phase = phase_mid;
                n_count = count_mid;
            end
            if (i_end_of_unit) begin
                n_phase     = PH_SEARCH;
                n_recent    = 24'hffffff;
                n_unit_open = 1'b0;
            end else begin
                n_recent = {r_recent[15:0], i_data_byte};
            end
        end

        // sequence one output byte per tick
        emit     = acc_t && r_pend_valid;
        pay      = (r_remain < CW'(r_chunk)) ? r_remain : CW'(r_chunk);
        last_pkt = r_frag ? (LW'(r_remain) <= LW'(r_chunk)) : 1'b1;
        pkt_end  = r_frag ? (r_pos == LW'(pay) + LW'(1)) : (r_pos == LW'(r_pend_len) - LW'(1));
        mem_sel  = !r_frag || (r_pos >= LW'(2));
        if (r_pos == '0) begin
            lit = (r_hdr & NRI_MASK) | FU_A_TYPE;
        end else begin
            lit = {r_first, last_pkt, 1'b0, r_hdr[4:0]};
        end
        rd_en = emit && mem_sel;
        beat_c.byte_val  = lit;
        beat_c.pkt_first = (r_pos == '0);
        beat_c.pkt_last  = pkt_end;
        beat_c.marker    = r_ending && last_pkt;
        beat_c.ptime     = r_pend_time;
        beat_c.ovf       = r_ovf;
        if (emit) begin
            if (mem_sel) begin
                n_ptr = wrap({1'b0, r_ptr} + (AW+1)'(1));
            end
            if (pkt_end) begin
                n_pos = '0;
                if (last_pkt) begin
                    n_pend_valid = 1'b0;
                end else begin
                    n_remain = r_remain - pay;
                    n_first  = 1'b0;
                end
            end else begin
                n_pos = r_pos + LW'(1);
            end
        end
    end

    // hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent <= 24'hffffff;  r_phase <= PH_SEARCH;  r_count <= '0;
            r_coll_start <= '0;  r_write_head <= '0;  r_coll_hdr <= '0;
            r_unit_open <= 1'b0;  r_unit_time <= '0;  r_ovf <= 1'b0;
            r_enable <= 1'b0;  r_mtu <= MTU_RESET;
            r_pend_valid <= 1'b0;  r_hdr <= '0;  r_pend_len <= '0;
            r_remain <= '0;  r_chunk <= '0;  r_frag <= 1'b0;  r_first <= 1'b1;
            r_ending <= 1'b0;  r_pend_time <= '0;  r_pos <= '0;  r_ptr <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            r_recent <= n_recent;  r_phase <= n_phase;  r_count <= n_count;
            r_coll_start <= n_coll_start;  r_write_head <= n_write_head;
            r_coll_hdr <= n_coll_hdr;  r_unit_open <= n_unit_open;
            r_unit_time <= n_unit_time;  r_ovf <= n_ovf;
            r_enable <= n_enable;  r_mtu <= n_mtu;
            r_pend_valid <= n_pend_valid;  r_hdr <= n_hdr;  r_pend_len <= n_pend_len;
            r_remain <= n_remain;  r_chunk <= n_chunk;  r_frag <= n_frag;
            r_first <= n_first;  r_ending <= n_ending;  r_pend_time <= n_pend_time;
            r_pos <= n_pos;  r_ptr <= n_ptr;
            r_s2_valid <= emit;
        end
    end

    // register the beat fields beside the store read
    always_ff @(posedge i_clk) begin
        r_s2_mem  <= mem_sel;
        r_s2_beat <= beat_c;
    end

    // write and read the NAL store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_data_byte;
        end
        if (rd_en) begin
            r_rdata <= mem[r_ptr];
        end
    end

    always_comb begin
        o_beat = r_s2_beat;
        if (r_s2_mem) begin
            o_beat.byte_val = r_rdata;
        end
    end
    assign o_beat_valid = r_s2_valid;

    a_pos_needs_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != '0) |-> r_pend_valid) else $error("packet position without pending NAL");
    a_ptr_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr < AW'(STORE_BYTES - 1) || r_ptr == AW'(STORE_BYTES - 1))
        else $error("read pointer outside store");
    a_single_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_valid && !r_frag) |-> (LW'(r_pend_len) > r_pos))
        else $error("single packet overran its NAL");
    a_beat_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> $past(acc_t)) else $error("beat without tick");

endmodule

// File: rtl/core/h264p_queue.sv
// Back end: short result queue that holds beats until the output side takes them.
// Depends on h264p_pkg (t_beat, Q_DEPTH).
module h264p_queue import h264p_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  t_beat                      i_beat,
    input  logic                       i_pop,
    output logic                       o_valid,
    output t_beat                      o_beat,
    output logic [$clog2(Q_DEPTH):0]   o_count
);

    localparam int unsigned PW = $clog2(Q_DEPTH);

    t_beat            r_slot [Q_DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [PW:0]      r_cnt, n_cnt;
    logic             pop_c;

    // advance pointers and count
    always_comb begin
        pop_c = i_pop && (r_cnt != '0);
        n_wr  = i_push ? r_wr + PW'(1) : r_wr;
        n_rd  = pop_c ? r_rd + PW'(1) : r_rd;
        n_cnt = r_cnt + (PW+1)'(i_push) - (PW+1)'(pop_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // hold beats
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_beat;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_beat  = r_slot[r_rd];
    assign o_count = r_cnt;

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt < (PW+1)'(Q_DEPTH) || pop_c)) else $error("queue overrun");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(Q_DEPTH)) else $error("queue count out of range");
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop_c) |=> (r_cnt == $past(r_cnt) + (PW+1)'(1)))
        else $error("queue count lost a push");

endmodule

// File: tb/tb_h264_annexb_to_rtp_fua_packetizer.sv
// Testbench for the Annex B to RTP FU-A packetizer: drives access units and ticks,
// predicts every payload byte in a scoreboard class and checks the output channel.
// Depends on h264p_pkg and h264_annexb_to_rtp_fua_packetizer.
`timescale 1ns / 1ps

module tb_h264_annexb_to_rtp_fua_packetizer;
    import h264p_pkg::*;

    typedef enum int {PARSE_SEARCH, PARSE_COLLECT, PARSE_DISCARD} t_parse;

    // Scoreboard: packetizer prediction plus queue of expected payload bytes
    class fua_scoreboard;
        bit [7:0]  store [2048];
        bit [23:0] recent;
        t_parse    phase;
        bit [7:0]  hdr_byte;
        bit [11:0] buf_count;
        bit [11:0] frag_off;
        bit        frag_mode;
        bit        first_frag;
        bit        unit_end;
        bit [31:0] unit_ts;
        bit        ovf;
        bit        en;
        bit [11:0] mtu;
        bit        unit_open;
        int        coll_start, write_head, pend_start, pend_len, chunk, pkt_pos;
        bit        pend_valid;
        bit [31:0] pend_ts;
        t_beat     expected_beats[$];
        int        errors;
        int        beats_seen;

        function new();
            recent = 24'hffffff;
            phase = PARSE_SEARCH;
            first_frag = 1'b1;
            mtu = MTU_RESET;
        endfunction

        function void write_reg(logic idx, bit [11:0] val);
            if (idx == CFG_ENABLE) en = val[0];
            else mtu = val;
        endfunction

        function void open_nal();
            phase = PARSE_COLLECT;
            buf_count = 0;
            coll_start = write_head;
        endfunction

        // Close the collected NAL and make it pending if it is kept
        function void close_nal(int len, bit last);
            bit [7:0] h;
            int m, lim;
            if (phase != PARSE_COLLECT || len < 2 || !en) return;
            h = store[coll_start % 2048];
            if (h[4:0] == NAL_SPS || h[4:0] == NAL_PPS) return;
            if (pend_valid) begin
                ovf = 1'b1;
                return;
            end
            pend_valid = 1'b1;
            pend_start = coll_start;
            pend_len = len;
            unit_end = last;
            pend_ts = unit_ts;
            hdr_byte = h;
            m = (mtu < MTU_FLOOR) ? MTU_FLOOR : mtu;
            lim = m - RTP_HEADER_BYTES;
            frag_mode = (len > lim);
            chunk = lim - 2;
            frag_off = frag_mode;
            first_frag = 1'b1;
            pkt_pos = 0;
            write_head = (coll_start + len) % 2048;
        endfunction

        function void store_byte(bit [7:0] b);
            int room;
            room = 2048 - (pend_valid ? pend_len : 0);
            if (phase == PARSE_COLLECT) begin
                if (buf_count < room) begin
                    store[(coll_start + buf_count) % 2048] = b;
                end else begin
                    phase = PARSE_DISCARD;
                    ovf = 1'b1;
                end
            end
            if (buf_count < 2051) buf_count++;
        endfunction

        // Note an accepted request and queue the byte it causes, if any
        function void note_item(logic cmd, bit [7:0] b, bit eou, bit [31:0] ts);
            bit sc;
            int len, remain, pay, plen;
            bit lastpkt;
            t_beat bt;
            if (cmd == CMD_BYTE) begin
                if (!unit_open) begin
                    unit_ts = ts;
                    unit_open = 1'b1;
                end
                sc = (recent[15:0] == 16'h0) && (b == 8'h01);
                if (phase == PARSE_SEARCH) begin
                    if (sc) open_nal();
                end else if (sc && buf_count >= 3) begin
                    len = buf_count - 2;
                    if (recent[23:16] == 8'h0) len--;
                    close_nal(len, 1'b0);
                    open_nal();
                end else begin
                    store_byte(b);
                end
                recent = {recent[15:0], b};
                if (eou) begin
                    if (phase != PARSE_SEARCH) close_nal(buf_count, 1'b1);
                    phase = PARSE_SEARCH;
                    recent = 24'hffffff;
                    unit_open = 1'b0;
                end
                return;
            end
            if (!pend_valid) return;
            if (frag_mode) begin
                remain = pend_len - frag_off;
                pay = (remain < chunk) ? remain : chunk;
                plen = pay + 2;
                lastpkt = (pay == remain);
                if (pkt_pos == 0)
                    bt.byte_val = (hdr_byte & NRI_MASK) | FU_A_TYPE;
                else if (pkt_pos == 1)
                    bt.byte_val = (first_frag ? 8'h80 : 8'h00) | (lastpkt ? 8'h40 : 8'h00)
                                  | (hdr_byte & TYPE_MASK);
                else
                    bt.byte_val = store[(pend_start + frag_off + pkt_pos - 2) % 2048];
            end else begin
                plen = pend_len;
                lastpkt = 1'b1;
                bt.byte_val = store[(pend_start + pkt_pos) % 2048];
            end
            bt.pkt_first = (pkt_pos == 0);
            bt.pkt_last = (pkt_pos + 1 == plen);
            bt.marker = unit_end && lastpkt;
            bt.ptime = pend_ts;
            bt.ovf = ovf;
            expected_beats.push_back(bt);
            if (pkt_pos + 1 >= plen) begin
                pkt_pos = 0;
                if (lastpkt) begin
                    pend_valid = 1'b0;
                end else begin
                    frag_off += pay;
                    first_frag = 1'b0;
                end
            end else begin
                pkt_pos++;
            end
        endfunction

        // Compare one output byte with the oldest expectation
        function void check_beat(t_beat got);
            t_beat exp_b;
            beats_seen++;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected output byte %h", $time, got.byte_val);
                errors++;
                return;
            end
            exp_b = expected_beats.pop_front();
            if (got.byte_val !== exp_b.byte_val) begin
                $display("%0t: out_byte exp %h got %h", $time, exp_b.byte_val, got.byte_val);
                errors++;
            end
            if (got.pkt_first !== exp_b.pkt_first) begin
                $display("%0t: packet_start exp %b got %b", $time, exp_b.pkt_first,
                         got.pkt_first);
                errors++;
            end
            if (got.pkt_last !== exp_b.pkt_last) begin
                $display("%0t: packet_end exp %b got %b", $time, exp_b.pkt_last, got.pkt_last);
                errors++;
            end
            if (got.marker !== exp_b.marker) begin
                $display("%0t: marker exp %b got %b", $time, exp_b.marker, got.marker);
                errors++;
            end
            if (got.ptime !== exp_b.ptime) begin
                $display("%0t: packet_time exp %h got %h", $time, exp_b.ptime, got.ptime);
                errors++;
            end
            if (got.ovf !== exp_b.ovf) begin
                $display("%0t: overflow exp %b got %b", $time, exp_b.ovf, got.ovf);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_command = CMD_BYTE;
    logic [7:0]         i_data_byte = 8'h0;
    logic               i_end_of_unit = 1'b0;
    logic signed [31:0] i_timestamp = 32'sh0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [7:0]         o_out_byte;
    logic               o_packet_start;
    logic               o_packet_end;
    logic               o_marker;
    logic signed [31:0] o_packet_time;
    logic               o_overflow;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index = CFG_ENABLE;
    logic [11:0]        i_cfg_data = 12'h0;

    fua_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent = 0;
    int units_sent = 0;

    h264_annexb_to_rtp_fua_packetizer dut (.*);

    always #10 i_clk = ~i_clk;

    // Check accepted output bytes and stall the receiver at random
    always @(posedge i_clk) begin
        t_beat got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.byte_val = o_out_byte;
            got.pkt_first = o_packet_start;
            got.pkt_last = o_packet_end;
            got.marker = o_marker;
            got.ptime = o_packet_time;
            got.ovf = o_overflow;
            sb.check_beat(got);
        end
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Hold one request until accepted, with an optional idle gap first
    task automatic push_item(logic cmd, bit [7:0] b, bit eou, bit [31:0] ts);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_data_byte <= b;
        i_end_of_unit <= eou;
        i_timestamp <= ts;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        sb.note_item(cmd, b, eou, ts);
        items_sent++;
    endtask

    task automatic push_byte(bit [7:0] b, bit eou = 1'b0);
        push_item(CMD_BYTE, b, eou, $urandom);
    endtask

    // Tick until nothing is left pending
    task automatic drain_ticks();
        while (sb.pend_valid) push_item(CMD_TICK, 8'($urandom), 1'($urandom), $urandom);
    endtask

    // Pause the sender until every expected byte has come out
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.expected_beats.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, bit [11:0] val);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // One access unit of NALs with random content, ticks mixed in
    task automatic send_unit(int max_body);
        int n_nal, body;
        bit [7:0] h, b;
        n_nal = $urandom_range(1, 3);
        repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
        for (int k = 0; k < n_nal; k++) begin
            if ($urandom_range(0, 1)) push_byte(8'h00);
            push_byte(8'h00);
            push_byte(8'h00);
            push_byte(8'h01);
            if ($urandom_range(0, 99) < 80) drain_ticks();
            h = 8'($urandom);
            if ($urandom_range(0, 9) == 0) h[4:0] = $urandom_range(0, 1) ? NAL_SPS : NAL_PPS;
            body = ($urandom_range(0, 19) == 0) ? $urandom_range(0, max_body)
                                                : $urandom_range(0, max_body / 4);
            push_byte(h, (k == n_nal - 1) && (body == 0));
            for (int j = 0; j < body; j++) begin
                b = ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom);
                push_byte(b, (k == n_nal - 1) && (j == body - 1));
                if ($urandom_range(0, 9) == 0) push_item(CMD_TICK, 8'h0, 1'b0, 32'h0);
            end
        end
        if ($urandom_range(0, 99) < 80) drain_ticks();
        units_sent++;
    endtask

    // Junk and broken sequences
    task automatic send_noise();
        repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 5) == 0) push_item(CMD_TICK, 8'($urandom), 1'b0, $urandom);
            else push_byte(($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom),
                           ($urandom_range(0, 7) == 0));
        end
    endtask

    // Complete a second kept NAL while the first is still pending
    task automatic overlap_units();
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h01);
        push_byte(8'h41);
        repeat (20) push_byte(8'($urandom_range(2, 255)));
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h01);
        push_byte(8'h65);
        repeat (10) push_byte(8'($urandom_range(2, 255)));
        push_byte(8'h55, 1'b1);
        drain_ticks();
    endtask

    initial begin
        int phase_items;
        bit [11:0] mtu_list [6];
        mtu_list = '{12'd16, 12'd0, 12'd2059, 12'd300, 12'd4095, 12'd100};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_cfg(CFG_ENABLE, 12'd1);

        // Directed: junk, 4-byte start code, extreme times, SPS drop, short NAL
        push_item(CMD_BYTE, 8'hff, 1'b0, 32'h8000_0000);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h01);
        push_byte(8'h65);
        push_byte(8'h00);
        push_byte(8'hff);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h01);
        push_byte(8'h67);
        push_byte(8'h42);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h01);
        push_byte(8'hfc, 1'b1);
        push_item(CMD_TICK, 8'h0, 1'b0, 32'h0);
        drain_ticks();
        push_item(CMD_BYTE, 8'h00, 1'b0, 32'h7fff_ffff);
        push_byte(8'h00);
        push_byte(8'h01);
        push_byte(8'h9f);
        push_byte(8'h80, 1'b1);
        drain_ticks();
        push_item(CMD_TICK, 8'hff, 1'b1, 32'hffff_ffff);

        // Random phases over several register settings and idle patterns
        for (int p = 0; p < 6; p++) begin
            send_idle_pct = (p < 2) ? 12 : (p < 4) ? 54 : 0;
            recv_idle_pct = (p < 2) ? 54 : (p < 4) ? 12 : 0;
            write_cfg(CFG_MTU, mtu_list[p]);
            write_cfg(CFG_ENABLE, (p == 3) ? 12'd0 : 12'd1);
            if (p == 2) overlap_units();
            phase_items = items_sent;
            while (items_sent - phase_items < 115) begin
                if ($urandom_range(0, 9) == 0) send_noise();
                else send_unit((mtu_list[p] <= 100) ? 60 : 240);
                if ($urandom_range(0, 19) == 0) wait_idle();
            end
            drain_ticks();
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d requests in %0d access units; checked %0d payload bytes.",
                 items_sent, units_sent, sb.beats_seen);
        $display("Covered mtu floor, maximum and oversize, disabled output and busy store.");
        if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
